// ===== rtl/cooling_law_temp_extrapolator_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cooling-law extrapolator
// Immediate-implication and next-cycle checks, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef COOLING_LAW_TEMP_EXTRAPOLATOR_ASSERT_SVH
`define COOLING_LAW_TEMP_EXTRAPOLATOR_ASSERT_SVH

// same-cycle implication
`define CLTE_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CLTE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/clte_pkg.sv =====
// ----------------------------------------------------------------------------
// clte_pkg
// Widths, depths, register codes and reset values of the extrapolator.
// ----------------------------------------------------------------------------
`default_nettype none

package clte_pkg;

  localparam int SAMPLE_DEPTH  = 32;
  localparam int AVERAGE_DEPTH = 16;

  localparam int TEMP_W     = 16;
  localparam int DECAY_W    = 24;
  localparam int SWIN_W     = 6;
  localparam int AWIN_W     = 5;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;

  localparam int SAMPLE_AW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int SAMPLE_CW = $clog2(SAMPLE_DEPTH + 1);
  localparam int AVG_AW    = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
  localparam int AVG_CW    = $clog2(AVERAGE_DEPTH + 1);

  localparam int EX_W   = DECAY_W + 1;          // Q0.24 incl. 1.0
  localparam int PROD_W = TEMP_W + EX_W + 1;
  localparam int NUM_W  = TEMP_W + DECAY_W + 4;
  localparam int DIV_W  = NUM_W + 4;
  localparam int QW     = TEMP_W;
  localparam int QCW    = $clog2(QW);
  localparam int SUM_W  = TEMP_W + AVG_AW + 1;

  localparam logic [EX_W-1:0] ONE_Q24 = EX_W'(1) << DECAY_W;

  localparam logic [SWIN_W-1:0]  SWIN_RESET  = SWIN_W'(20);
  localparam logic [AWIN_W-1:0]  AWIN_RESET  = AWIN_W'(5);
  localparam logic [DECAY_W-1:0] DECAY_RESET = DECAY_W'(16755017);

  localparam logic CMD_SAMPLE  = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_WINDOW  = 2'd0,
    CFG_AVERAGE_WINDOW = 2'd1,
    CFG_DECAY          = 2'd2
  } cfg_index_t;

  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sh7FFF;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = -16'sh8000;

endpackage

`default_nettype wire

// ===== rtl/clte_if.sv =====
// ----------------------------------------------------------------------------
// clte channel interfaces
// Sample/command word in, result word out; valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface clte_item_if import clte_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic signed [TEMP_W-1:0] sample_temp;

  modport source (output valid, command, sample_temp, input ready);
  modport sink   (input valid, command, sample_temp, output ready);
endinterface

interface clte_result_if import clte_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] averaged_temp;
  logic signed [TEMP_W-1:0] extrapolated_temp;
  logic                     saturated;

  modport source (output valid, averaged_temp, extrapolated_temp, saturated, input ready);
  modport sink   (input valid, averaged_temp, extrapolated_temp, saturated, output ready);
endinterface

`default_nettype wire

// ===== rtl/clte_ram.sv =====
// ----------------------------------------------------------------------------
// clte_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module clte_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cooling_law_temp_extrapolator.sv =====
// ----------------------------------------------------------------------------
// cooling_law_temp_extrapolator
// Newton cooling-law end-temperature predictor with result averaging.
// ----------------------------------------------------------------------------
// One word at a time. A restart word, or a sample that leaves fewer than two
// samples held, gives no result. Any other sample runs the steps in order:
// the oldest held sample is read, the decay power is raised once per held
// sample less one, the numerator is formed and divided, the result is written
// to the averaging ring, the ring is summed and divided by its fill, and the
// word is offered. An extrapolation that overflows is clamped without running
// the first division. The decay power runs one step a cycle on a single 25x24
// multiplier, both roundings share one 16-step restoring divider, and the
// averaging ring is summed one entry a cycle from its RAM. Input ready is high
// only while the block is idle. Both rings sit in RAM and need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cooling_law_temp_extrapolator_assert.svh"

module cooling_law_temp_extrapolator import clte_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  clte_item_if.sink                  sample_in,
  clte_result_if.source              result_out
);

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_POW, S_MUL, S_NUM, S_DIV, S_RES, S_SUM, S_OUT
  } state_t;

  state_t state;

  // configuration
  logic [SWIN_W-1:0]  sample_window;
  logic [AWIN_W-1:0]  average_window;
  logic [DECAY_W-1:0] decay_per_sample;

  // ring bookkeeping
  logic [SAMPLE_AW-1:0] s_head;
  logic [SAMPLE_CW-1:0] s_count;
  logic [AVG_AW-1:0]    r_head;
  logic [AVG_CW-1:0]    r_count;

  // datapath
  logic signed [TEMP_W-1:0] newest;
  logic [SAMPLE_AW-1:0]     rd_addr;
  logic [SAMPLE_CW-1:0]     iter;
  logic [EX_W-1:0]          ex;
  logic signed [PROD_W-1:0] prod_oe;
  logic [EX_W-1:0]          den;
  logic [DIV_W-1:0]         rem;
  logic [DIV_W-1:0]         dsh;
  logic [QW-1:0]            quo;
  logic [QCW-1:0]           dcnt;
  logic                     div_neg;
  logic                     div_mean;
  logic signed [TEMP_W-1:0] end_val;
  logic                     sat;
  logic signed [SUM_W-1:0]  sum;
  logic [AVG_CW-1:0]        sum_rd;
  logic                     acc_v;

  // output register
  logic                     out_valid;
  logic signed [TEMP_W-1:0] out_avg;
  logic signed [TEMP_W-1:0] out_ext;
  logic                     out_sat;

  // RAM ports
  logic [TEMP_W-1:0] s_rdata;
  logic [TEMP_W-1:0] r_rdata;
  logic              s_we;
  logic              r_we;
  logic              r_re;

  // comb
  logic [SAMPLE_CW-1:0]   ws;
  logic [AVG_CW-1:0]      wa;
  logic [SAMPLE_CW-1:0]   s_head_p1;
  logic [SAMPLE_AW-1:0]   s_idx;
  logic [SAMPLE_CW:0]     s_cnt_p1;
  logic [SAMPLE_CW-1:0]   s_cnt_new;
  logic [SAMPLE_CW-1:0]   s_idx_p1;
  logic [SAMPLE_AW-1:0]   s_old;
  logic [AVG_CW-1:0]      r_head_p1;
  logic [AVG_AW-1:0]      r_idx;
  logic [AVG_CW:0]        r_cnt_p1;
  logic [AVG_CW-1:0]      r_cnt_new;
  logic [EX_W+DECAY_W-1:0] ex_prod;
  logic [EX_W+DECAY_W-1:0] ex_rnd;
  logic [EX_W-1:0]        ex_next;
  logic signed [NUM_W-1:0] num;
  logic                   num_neg;
  logic [NUM_W-1:0]       num_mag;
  logic [DIV_W-1:0]       ext_d;
  logic                   ext_ovf;
  logic                   sum_neg;
  logic [SUM_W-1:0]       sum_mag;
  logic [DIV_W-1:0]       mean_d;
  logic [DIV_W:0]         div_sub;
  logic                   q_bit;
  logic [QW-1:0]          q_fin;
  logic                   accept;

  assign accept = sample_in.valid && sample_in.ready;

  always_comb begin
    if (int'(sample_window) < 2) begin
      ws = SAMPLE_CW'(2);
    end else if (int'(sample_window) > SAMPLE_DEPTH) begin
      ws = SAMPLE_CW'(SAMPLE_DEPTH);
    end else begin
      ws = SAMPLE_CW'(sample_window);
    end
    if (int'(average_window) < 1) begin
      wa = AVG_CW'(1);
    end else if (int'(average_window) > AVERAGE_DEPTH) begin
      wa = AVG_CW'(AVERAGE_DEPTH);
    end else begin
      wa = AVG_CW'(average_window);
    end
  end

  // ring pushes: counts clamp and heads wrap against the current window
  always_comb begin
    s_head_p1 = SAMPLE_CW'(s_head) + SAMPLE_CW'(1);
    s_idx     = (s_count == '0 || s_head_p1 >= ws) ? '0 : s_head_p1[SAMPLE_AW-1:0];
    s_cnt_p1  = (SAMPLE_CW+1)'(s_count) + (SAMPLE_CW+1)'(1);
    s_cnt_new = (s_cnt_p1 < (SAMPLE_CW+1)'(ws)) ? s_cnt_p1[SAMPLE_CW-1:0] : ws;
    s_idx_p1  = SAMPLE_CW'(s_idx) + SAMPLE_CW'(1);
    s_old     = (s_cnt_new < ws || s_idx_p1 >= ws) ? '0 : s_idx_p1[SAMPLE_AW-1:0];

    r_head_p1 = AVG_CW'(r_head) + AVG_CW'(1);
    r_idx     = (r_count == '0 || r_head_p1 >= wa) ? '0 : r_head_p1[AVG_AW-1:0];
    r_cnt_p1  = (AVG_CW+1)'(r_count) + (AVG_CW+1)'(1);
    r_cnt_new = (r_cnt_p1 < (AVG_CW+1)'(wa)) ? r_cnt_p1[AVG_CW-1:0] : wa;
  end

  // one power step, rounded half up back to Q0.24
  always_comb begin
    ex_prod = (EX_W+DECAY_W)'(ex) * (EX_W+DECAY_W)'(decay_per_sample);
    ex_rnd  = ex_prod + (EX_W+DECAY_W)'(ONE_Q24 >> 1);
    ex_next = ex_rnd[DECAY_W +: EX_W];
  end

  // numerator, dividend set-up for both divisions
  always_comb begin
    num     = (NUM_W'(newest) <<< DECAY_W) - NUM_W'(prod_oe);
    num_neg = num[NUM_W-1];
    num_mag = num_neg ? NUM_W'(-num) : NUM_W'(num);
    ext_d   = DIV_W'(num_mag) + DIV_W'(den >> 1);
    ext_ovf = ext_d >= (DIV_W'(den) << QW);

    sum_neg = sum[SUM_W-1];
    sum_mag = sum_neg ? SUM_W'(-sum) : SUM_W'(sum);
    mean_d  = DIV_W'(sum_mag) + DIV_W'(r_count >> 1);

    div_sub = (DIV_W+1)'(rem) - (DIV_W+1)'(dsh);
    q_bit   = !div_sub[DIV_W];
    q_fin   = {quo[QW-2:0], q_bit};
  end

  assign s_we = (state == S_IDLE) && accept && (sample_in.command == CMD_SAMPLE);
  assign r_we = (state == S_RES);
  assign r_re = (state == S_SUM) && (sum_rd < r_count);

  clte_ram #(.WIDTH(TEMP_W), .DEPTH(SAMPLE_DEPTH)) u_sample_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_idx),
    .wdata (sample_in.sample_temp),
    .re    (state == S_READ),
    .raddr (rd_addr),
    .rdata (s_rdata)
  );

  clte_ram #(.WIDTH(TEMP_W), .DEPTH(AVERAGE_DEPTH)) u_result_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_idx),
    .wdata (end_val),
    .re    (r_re),
    .raddr (sum_rd[AVG_AW-1:0]),
    .rdata (r_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      sample_window    <= SWIN_RESET;
      average_window   <= AWIN_RESET;
      decay_per_sample <= DECAY_RESET;
      s_head           <= '0;
      s_count          <= '0;
      r_head           <= '0;
      r_count          <= '0;
      out_valid        <= 1'b0;
      acc_v            <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SAMPLE_WINDOW:  sample_window    <= cfg_data[SWIN_W-1:0];
          CFG_AVERAGE_WINDOW: average_window   <= cfg_data[AWIN_W-1:0];
          CFG_DECAY:          decay_per_sample <= cfg_data[DECAY_W-1:0];
          default:            ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            if (sample_in.command == CMD_RESTART) begin
              s_head  <= '0;
              s_count <= '0;
              r_head  <= '0;
              r_count <= '0;
            end else begin
              s_head  <= s_idx;
              s_count <= s_cnt_new;
              newest  <= sample_in.sample_temp;
              rd_addr <= s_old;
              iter    <= s_cnt_new - SAMPLE_CW'(1);
              ex      <= ONE_Q24;
              if (s_cnt_new >= SAMPLE_CW'(2)) begin
                state <= S_READ;
              end
            end
          end
        end

        S_READ: state <= S_POW;

        S_POW: begin
          if (iter != '0) begin
            ex   <= ex_next;
            iter <= iter - SAMPLE_CW'(1);
          end else begin
            state <= S_MUL;
          end
        end

        S_MUL: begin
          prod_oe <= $signed(s_rdata) * $signed({1'b0, ex});
          den     <= ONE_Q24 - ex;
          state   <= S_NUM;
        end

        S_NUM: begin
          div_neg  <= num_neg;
          div_mean <= 1'b0;
          if (den == '0) begin
            end_val <= '0;
            sat     <= 1'b1;
            state   <= S_RES;
          end else if (ext_ovf) begin
            end_val <= num_neg ? TEMP_MIN : TEMP_MAX;
            sat     <= 1'b1;
            state   <= S_RES;
          end else begin
            rem   <= ext_d;
            dsh   <= DIV_W'(den) << (QW - 1);
            quo   <= '0;
            dcnt  <= QCW'(QW - 1);
            state <= S_DIV;
          end
        end

        // shared restoring divider, one quotient bit a cycle
        S_DIV: begin
          if (q_bit) begin
            rem <= div_sub[DIV_W-1:0];
          end
          quo  <= q_fin;
          dsh  <= dsh >> 1;
          dcnt <= dcnt - QCW'(1);
          if (dcnt == '0) begin
            if (div_mean) begin
              out_avg   <= div_neg ? TEMP_W'(-q_fin) : TEMP_W'(q_fin);
              out_ext   <= end_val;
              out_sat   <= sat;
              out_valid <= 1'b1;
              state     <= S_OUT;
            end else begin
              if (!div_neg) begin
                sat     <= q_fin > QW'(TEMP_MAX);
                end_val <= (q_fin > QW'(TEMP_MAX)) ? TEMP_MAX : TEMP_W'(q_fin);
              end else begin
                sat     <= q_fin > QW'(32768);
                end_val <= (q_fin > QW'(32768)) ? TEMP_MIN : TEMP_W'(-q_fin);
              end
              state <= S_RES;
            end
          end
        end

        S_RES: begin
          r_head  <= r_idx;
          r_count <= r_cnt_new;
          sum     <= '0;
          sum_rd  <= '0;
          acc_v   <= 1'b0;
          state   <= S_SUM;
        end

        // read one entry a cycle, add it the cycle after
        S_SUM: begin
          acc_v <= r_re;
          if (r_re) begin
            sum_rd <= sum_rd + AVG_CW'(1);
          end
          if (acc_v) begin
            sum <= sum + SUM_W'($signed(r_rdata));
          end
          if (!r_re && !acc_v) begin
            div_neg  <= sum_neg;
            div_mean <= 1'b1;
            rem      <= mean_d;
            dsh      <= DIV_W'(r_count) << (QW - 1);
            quo      <= '0;
            dcnt     <= QCW'(QW - 1);
            state    <= S_DIV;
          end
        end

        S_OUT: begin
          if (result_out.ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign sample_in.ready              = (state == S_IDLE);
  assign result_out.valid             = out_valid;
  assign result_out.averaged_temp     = out_avg;
  assign result_out.extrapolated_temp = out_ext;
  assign result_out.saturated         = out_sat;

  `CLTE_ASSERT_NOW(a_out_only_in_out_state, out_valid, state == S_OUT, "result word outside output state")
  `CLTE_ASSERT_NEXT(a_restart_clears, accept && sample_in.command == CMD_RESTART, s_count == '0 && r_count == '0, "restart left rings filled")
  `CLTE_ASSERT_NOW(a_sat_value, out_valid && out_sat, out_ext == TEMP_MAX || out_ext == TEMP_MIN || out_ext == '0, "saturated word with unclamped value")
  `CLTE_ASSERT_NOW(a_counts_bounded, 1'b1, s_count <= SAMPLE_CW'(SAMPLE_DEPTH) && r_count <= AVG_CW'(AVERAGE_DEPTH), "ring count beyond depth")

endmodule

`default_nettype wire
